>>> rtl/core/ptl_pkg.sv
// ----------------------------------------------------------------------------
// ptl_pkg
// types, codes and constants shared by the profile_tier_level parser files
// ----------------------------------------------------------------------------
package ptl_pkg;

	localparam int MAX_SUB_LAYERS_DEF = 8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_PROFILE_PRESENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SUB_LAYERS  = 1'd1;

	typedef enum logic [4:0] {
		PH_SPACE     = 5'd0,
		PH_TIER      = 5'd1,
		PH_IDC       = 5'd2,
		PH_COMPAT    = 5'd3,
		PH_CONSTR    = 5'd4,
		PH_RESV      = 5'd5,
		PH_INBLD     = 5'd6,
		PH_LEVEL     = 5'd7,
		PH_SLPF      = 5'd8,
		PH_SLLF      = 5'd9,
		PH_PAD       = 5'd10,
		PH_SL_SPACE  = 5'd11,
		PH_SL_TIER   = 5'd12,
		PH_SL_IDC    = 5'd13,
		PH_SL_COMPAT = 5'd14,
		PH_SL_CONSTR = 5'd15,
		PH_SL_RESV   = 5'd16,
		PH_SL_INBLD  = 5'd17,
		PH_SL_LEVEL  = 5'd18,
		PH_FINISHED  = 5'd19
	} phase_t;

	typedef enum logic [3:0] {
		EC_SPACE   = 4'd0,
		EC_TIER    = 4'd1,
		EC_IDC     = 4'd2,
		EC_COMPAT  = 4'd3,
		EC_CONSTR  = 4'd4,
		EC_INBLD   = 4'd5,
		EC_LEVEL   = 4'd6,
		EC_SL_PROF = 4'd7,
		EC_SL_LVL  = 4'd8,
		EC_DONE    = 4'd9,
		EC_TRUNC   = 4'd10
	} elem_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BIT,
		ST_FIN,
		ST_END
	} ctrl_state_t;

	typedef enum logic [1:0] {
		RS_ELEM,
		RS_DONE,
		RS_TRUNC
	} res_sel_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		elem_code_t  elem_code;
		logic [2:0]  layer;
		logic [31:0] value;
		logic [4:0]  effective_profile;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic load_byte;
		logic step;
		logic rearm;
	} dp_cmd_t;

	typedef struct packed {
		logic emit;
		logic finish;
		logic finished;
		logic last;
	} dp_status_t;

	typedef struct packed {
		logic     load;
		res_sel_t sel;
	} out_cmd_t;

endpackage

>>> rtl/core/ptl_dp.sv
// ----------------------------------------------------------------------------
// ptl_dp
// parser datapath: config registers, byte shifter, syntax phase, field
// accumulator, sub-layer flags and running effective profile
// ----------------------------------------------------------------------------
module ptl_dp #(
	parameter int MAX_SUB_LAYERS = ptl_pkg::MAX_SUB_LAYERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ptl_pkg::in_item_t              in_data,
	input  logic                           cfg_we,
	input  logic [ptl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  ptl_pkg::dp_cmd_t               cmd,
	output ptl_pkg::dp_status_t            status,
	output ptl_pkg::out_item_t             elem,
	output logic [4:0]                     eff_prof
);
	import ptl_pkg::*;

	localparam int         FW       = MAX_SUB_LAYERS;
	localparam logic [5:0] PAD_BASE = 6'(2 * MAX_SUB_LAYERS);
	localparam logic [2:0] N_MAX    = 3'(MAX_SUB_LAYERS - 1);

	logic          prof_present_q;
	logic [2:0]    msl_q;
	logic [7:0]    byte_q;
	logic          last_q;
	phase_t        phase_q;
	logic [5:0]    bcnt_q;
	logic [31:0]   accum_q;
	logic [2:0]    idx_q;
	logic [FW-1:0] sl_prof_q;
	logic [FW-1:0] sl_lvl_q;
	logic [4:0]    eff_q;

	logic [2:0]    n;
	logic          bit_v;
	logic          active;
	logic          complete;
	logic          has_code;
	logic          finish_v;
	phase_t        ph;
	elem_code_t    code;
	logic [31:0]   acc;
	logic [5:0]    cnt;
	logic [5:0]    len;
	logic [2:0]    layer;
	logic [3:0]    idx_inc;
	logic [FW-1:0] idx_bit;
	logic [3:0]    adv_start;
	logic          adv_found;
	logic [2:0]    adv_idx;
	logic          adv_prof;

	phase_t        phase_n;
	logic [5:0]    bcnt_n;
	logic [31:0]   accum_n;
	logic [2:0]    idx_n;
	logic [FW-1:0] sl_prof_n;
	logic [FW-1:0] sl_lvl_n;
	logic [4:0]    eff_n;

	always_comb begin
		n        = (msl_q > N_MAX) ? N_MAX : msl_q;
		bit_v    = byte_q[7];
		ph       = (phase_q == PH_SPACE && bcnt_q == 6'd0 && !prof_present_q) ?
			PH_LEVEL : phase_q;
		active   = (phase_q != PH_FINISHED);
		acc      = {accum_q[30:0], bit_v};
		cnt      = bcnt_q + 6'd1;
		idx_inc  = {1'b0, idx_q} + 4'd1;
		idx_bit  = FW'(1) << idx_q;
		has_code = 1'b1;
		code     = EC_SPACE;
		len      = 6'd1;
		case (ph)
			PH_SPACE, PH_SL_SPACE: begin
				len  = 6'd2;
				code = EC_SPACE;
			end
			PH_TIER, PH_SL_TIER:     code = EC_TIER;
			PH_IDC, PH_SL_IDC: begin
				len  = 6'd5;
				code = EC_IDC;
			end
			PH_COMPAT, PH_SL_COMPAT: begin
				len  = 6'd32;
				code = EC_COMPAT;
			end
			PH_CONSTR, PH_SL_CONSTR: begin
				len  = 6'd14;
				code = EC_CONSTR;
			end
			PH_RESV, PH_SL_RESV: begin
				len      = 6'd33;
				has_code = 1'b0;
			end
			PH_INBLD, PH_SL_INBLD:   code = EC_INBLD;
			PH_LEVEL, PH_SL_LEVEL: begin
				len  = 6'd8;
				code = EC_LEVEL;
			end
			PH_SLPF:                 code = EC_SL_PROF;
			PH_SLLF:                 code = EC_SL_LVL;
			PH_PAD: begin
				len      = PAD_BASE - {2'b00, n, 1'b0};
				has_code = 1'b0;
			end
			default:                 has_code = 1'b0;
		endcase
		complete = active && (cnt >= len);
		layer    = (ph >= PH_SLPF && ph != PH_PAD) ? idx_inc[2:0] : 3'd0;

		// lowest pending sub-layer at or after the start point
		adv_start = (ph == PH_PAD) ? 4'd0 : idx_inc;
		adv_found = 1'b0;
		adv_idx   = 3'd0;
		adv_prof  = 1'b0;
		for (int i = MAX_SUB_LAYERS - 2; i >= 0; i--) begin
			if (4'(i) >= adv_start && 3'(i) < n && (sl_prof_q[i] || sl_lvl_q[i])) begin
				adv_found = 1'b1;
				adv_idx   = 3'(i);
				adv_prof  = sl_prof_q[i];
			end
		end

		phase_n   = phase_q;
		bcnt_n    = bcnt_q;
		accum_n   = accum_q;
		idx_n     = idx_q;
		sl_prof_n = sl_prof_q;
		sl_lvl_n  = sl_lvl_q;
		eff_n     = eff_q;
		finish_v  = 1'b0;
		if (active) begin
			phase_n = ph;
			bcnt_n  = cnt;
			accum_n = acc;
			// compat flags arrive in ascending order, the last set one wins
			if (ph == PH_COMPAT && bit_v && bcnt_q[4:0] > eff_q)
				eff_n = bcnt_q[4:0];
			if (complete) begin
				bcnt_n  = 6'd0;
				accum_n = 32'd0;
				case (ph)
					PH_IDC: begin
						eff_n   = acc[4:0];
						phase_n = PH_COMPAT;
					end
					PH_LEVEL: begin
						if (n != 3'd0) begin
							idx_n   = 3'd0;
							phase_n = PH_SLPF;
						end else begin
							finish_v = 1'b1;
						end
					end
					PH_SLPF: begin
						if (acc[0])
							sl_prof_n = sl_prof_q | idx_bit;
						phase_n = PH_SLLF;
					end
					PH_SLLF: begin
						if (acc[0])
							sl_lvl_n = sl_lvl_q | idx_bit;
						if (idx_inc < {1'b0, n}) begin
							idx_n   = idx_inc[2:0];
							phase_n = PH_SLPF;
						end else begin
							phase_n = PH_PAD;
						end
					end
					PH_PAD, PH_SL_LEVEL, PH_SL_INBLD: begin
						if (ph == PH_SL_INBLD && (sl_lvl_q & idx_bit) != '0) begin
							phase_n = PH_SL_LEVEL;
						end else if (adv_found) begin
							idx_n   = adv_idx;
							phase_n = adv_prof ? PH_SL_SPACE : PH_SL_LEVEL;
						end else begin
							finish_v = 1'b1;
						end
					end
					default:  phase_n = phase_t'(ph + 5'd1);
				endcase
				if (finish_v)
					phase_n = PH_FINISHED;
			end
		end

		status.emit     = complete && has_code;
		status.finish   = finish_v;
		status.finished = !active;
		status.last     = last_q;

		elem.elem_code         = code;
		elem.layer             = layer;
		elem.value             = acc;
		elem.effective_profile = 5'd0;
		elem.last              = 1'b0;

		eff_prof = prof_present_q ? eff_q : 5'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prof_present_q <= 1'b1;
			msl_q          <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROFILE_PRESENT: prof_present_q <= cfg_wdata[0];
				CFG_MAX_SUB_LAYERS:  msl_q          <= cfg_wdata;
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte)
			byte_q <= in_data.byte_in;
		else if (cmd.step)
			byte_q <= {byte_q[6:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 1'b0;
			phase_q   <= PH_SPACE;
			bcnt_q    <= 6'd0;
			accum_q   <= 32'd0;
			idx_q     <= 3'd0;
			sl_prof_q <= '0;
			sl_lvl_q  <= '0;
			eff_q     <= 5'd0;
		end else begin
			if (cmd.load_byte)
				last_q <= in_data.last_byte;
			if (cmd.rearm) begin
				phase_q   <= PH_SPACE;
				bcnt_q    <= 6'd0;
				accum_q   <= 32'd0;
				idx_q     <= 3'd0;
				sl_prof_q <= '0;
				sl_lvl_q  <= '0;
				eff_q     <= 5'd0;
			end else if (cmd.step) begin
				phase_q   <= phase_n;
				bcnt_q    <= bcnt_n;
				accum_q   <= accum_n;
				idx_q     <= idx_n;
				sl_prof_q <= sl_prof_n;
				sl_lvl_q  <= sl_lvl_n;
				eff_q     <= eff_n;
			end
		end
	end

endmodule

>>> rtl/core/ptl_out.sv
// ----------------------------------------------------------------------------
// ptl_out
// output register: holds one result until the downstream side takes it
// ----------------------------------------------------------------------------
module ptl_out (
	input  logic               clk,
	input  logic               arst_n,
	input  ptl_pkg::out_cmd_t  cmd,
	input  ptl_pkg::out_item_t elem,
	input  logic [4:0]         eff_prof,
	output logic               free,
	output logic               out_valid,
	input  logic               out_ready,
	output ptl_pkg::out_item_t out_data
);
	import ptl_pkg::*;

	logic      valid_q;
	out_item_t data_q;
	out_item_t d;

	always_comb begin
		case (cmd.sel)
			RS_ELEM:  d = elem;
			RS_DONE:  d = '{elem_code: EC_DONE, layer: 3'd0, value: 32'd0,
				effective_profile: eff_prof, last: 1'b1};
			RS_TRUNC: d = '{elem_code: EC_TRUNC, layer: 3'd0, value: 32'd0,
				effective_profile: 5'd0, last: 1'b1};
			default:  d = elem;
		endcase
		free = !valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.load)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			data_q <= d;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

>>> rtl/core/ptl_ctrl.sv
// ----------------------------------------------------------------------------
// ptl_ctrl
// sequencer: takes a byte, steps its bits until the eighth or until done,
// issues done and truncated results and rearms at end of buffer
// ----------------------------------------------------------------------------
module ptl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ptl_pkg::dp_status_t status,
	input  logic                out_free,
	output ptl_pkg::dp_cmd_t    dp_cmd,
	output ptl_pkg::out_cmd_t   out_cmd
);
	import ptl_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_n;
	logic [2:0]  bit_q;
	logic [2:0]  bit_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= 3'd0;
		end else begin
			state_q <= state_n;
			bit_q   <= bit_n;
		end
	end

	always_comb begin
		state_n      = state_q;
		bit_n        = bit_q;
		in_ready     = 1'b0;
		dp_cmd       = '0;
		out_cmd.load = 1'b0;
		out_cmd.sel  = RS_ELEM;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dp_cmd.load_byte = 1'b1;
					bit_n            = 3'd0;
					state_n          = ST_BIT;
				end
			end
			ST_BIT: begin
				if (!(status.emit && !out_free)) begin
					dp_cmd.step  = 1'b1;
					out_cmd.load = status.emit;
					if (status.finish)
						state_n = ST_FIN;
					else if (bit_q == 3'd7)
						state_n = status.last ? ST_END : ST_IDLE;
					else
						bit_n = bit_q + 3'd1;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_cmd.load = 1'b1;
					out_cmd.sel  = RS_DONE;
					state_n      = status.last ? ST_END : ST_IDLE;
				end
			end
			ST_END: begin
				if (status.finished) begin
					dp_cmd.rearm = 1'b1;
					state_n      = ST_IDLE;
				end else if (out_free) begin
					out_cmd.load = 1'b1;
					out_cmd.sel  = RS_TRUNC;
					dp_cmd.rearm = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/core/hevc_profile_tier_level_parser.sv
// ----------------------------------------------------------------------------
// hevc_profile_tier_level_parser
// profile_tier_level syntax parser, one request byte in, element results out
// ----------------------------------------------------------------------------
// timing: a result is offered the cycle after the bit step that completes it;
//   a taken byte is registered and its bits stepped in ST_BIT, each step held
//   while its result cannot enter the output register; no new byte is taken
//   until its steps end; once done is reached the remaining steps are skipped
//   and done is issued from ST_FIN; a byte marked last adds a rearm in ST_END
// reset: asynchronous, parser at start of structure, registers at defaults
module hevc_profile_tier_level_parser #(
	parameter int MAX_SUB_LAYERS = ptl_pkg::MAX_SUB_LAYERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ptl_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ptl_pkg::out_item_t             out_data,
	input  logic                           cfg_we,
	input  logic [ptl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ptl_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t status;
	out_cmd_t   out_cmd;
	out_item_t  elem;
	logic [4:0] eff_prof;
	logic       out_free;

	ptl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.out_free (out_free),
		.dp_cmd   (dp_cmd),
		.out_cmd  (out_cmd)
	);

	ptl_dp #(
		.MAX_SUB_LAYERS (MAX_SUB_LAYERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (dp_cmd),
		.status    (status),
		.elem      (elem),
		.eff_prof  (eff_prof)
	);

	ptl_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (out_cmd),
		.elem      (elem),
		.eff_prof  (eff_prof),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> rtl/core/ptl_checker.sv
// ----------------------------------------------------------------------------
// ptl_port_checks
// port-level checks on the parser, bound to the top level
// ----------------------------------------------------------------------------
module ptl_port_checks (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input ptl_pkg::out_item_t out_data
);
	import ptl_pkg::*;

	logic end_code;

	assign end_code = (out_data.elem_code == EC_DONE) || (out_data.elem_code == EC_TRUNC);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_one_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("byte request taken while a byte is in work");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_code |-> out_data.last && out_data.layer == 3'd0 &&
			out_data.value == 32'd0)
		else $error("done or truncated result malformed");

	a_elem_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_code |-> !out_data.last && out_data.effective_profile == 5'd0)
		else $error("element result carries end fields");

endmodule

bind hevc_profile_tier_level_parser ptl_port_checks u_ptl_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

>>> sim/ptl_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptl_checker
// watches the byte and element channels of the profile_tier_level parser,
// keeps its own bit-serial parse of every taken byte and compares each
// element result, field by field, with the oldest one it has worked out
// ----------------------------------------------------------------------------
module ptl_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  ptl_pkg::in_item_t              in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  ptl_pkg::out_item_t             out_data,
	input  logic                           cfg_we,
	input  logic [ptl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                             mismatches,
	output int                             outstanding
);
	import ptl_pkg::*;

	localparam int MAX_PER_BYTE = 9;

	logic        prof_present;
	logic [2:0]  sub_layers_m1;

	phase_t      cur_phase;
	int          bits_in_field;
	logic [32:0] shift_acc;
	logic [2:0]  sl_cur;
	logic [6:0]  sl_prof_seen;
	logic [6:0]  sl_lvl_seen;
	logic [4:0]  gen_idc;
	logic [31:0] gen_compat;

	out_item_t   expected_elems[$];
	int          elems_this_byte;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns mismatch %s: got %0h expected %0h", $time, what, got, want);
		mismatches = mismatches + 1;
	endtask

	function automatic void restart_structure();
		cur_phase     = PH_SPACE;
		bits_in_field = 0;
		shift_acc     = '0;
		sl_cur        = '0;
		sl_prof_seen  = '0;
		sl_lvl_seen   = '0;
		gen_idc       = '0;
		gen_compat    = '0;
	endfunction

	function automatic int sub_count();
		int n;
		n = int'(sub_layers_m1);
		if (n > MAX_SUB_LAYERS_DEF - 1)
			n = MAX_SUB_LAYERS_DEF - 1;
		return n;
	endfunction

	function automatic void add_elem(input elem_code_t code, input logic [2:0] layer,
			input logic [31:0] value, input logic [4:0] prof, input logic last);
		out_item_t e;
		if (elems_this_byte >= MAX_PER_BYTE)
			return;
		e.elem_code         = code;
		e.layer             = layer;
		e.value             = value;
		e.effective_profile = prof;
		e.last              = last;
		expected_elems.push_back(e);
		elems_this_byte++;
	endfunction

	function automatic logic [4:0] best_profile();
		logic [4:0] p;
		if (!prof_present)
			return '0;
		p = gen_idc;
		for (int c = int'(gen_idc) + 1; c < 32; c++)
			if (gen_compat[31 - c])
				p = c[4:0];
		return p;
	endfunction

	function automatic void close_structure();
		add_elem(EC_DONE, '0, '0, best_profile(), 1'b1);
		cur_phase = PH_FINISHED;
	endfunction

	function automatic void next_sub_layer(input int first);
		int n;
		n = sub_count();
		for (int i = first; i < n && i < 7; i++) begin
			if (sl_prof_seen[i]) begin
				sl_cur    = i[2:0];
				cur_phase = PH_SL_SPACE;
				return;
			end
			if (sl_lvl_seen[i]) begin
				sl_cur    = i[2:0];
				cur_phase = PH_SL_LEVEL;
				return;
			end
		end
		close_structure();
	endfunction

	function automatic void shift_in_bit(input logic b);
		int          len;
		bit          has_code;
		elem_code_t  code;
		logic [2:0]  layer;
		phase_t      ph;
		phase_t      base;
		logic [2:0]  idx;
		logic [32:0] v;
		if (cur_phase == PH_FINISHED)
			return;
		if (cur_phase == PH_SPACE && bits_in_field == 0 && !prof_present)
			cur_phase = PH_LEVEL;
		ph            = cur_phase;
		idx           = sl_cur;
		shift_acc     = {shift_acc[31:0], b};
		bits_in_field = bits_in_field + 1;
		has_code      = 1'b1;
		code          = EC_SPACE;
		len           = 1;
		if (ph == PH_SLPF) begin
			code = EC_SL_PROF;
		end else if (ph == PH_SLLF) begin
			code = EC_SL_LVL;
		end else if (ph == PH_PAD) begin
			len      = 2 * (MAX_SUB_LAYERS_DEF - sub_count());
			has_code = 1'b0;
		end else begin
			base = (ph >= PH_SL_SPACE) ? phase_t'(ph - PH_SL_SPACE) : ph;
			case (base)
				PH_SPACE: begin
					len  = 2;
					code = EC_SPACE;
				end
				PH_TIER: begin
					len  = 1;
					code = EC_TIER;
				end
				PH_IDC: begin
					len  = 5;
					code = EC_IDC;
				end
				PH_COMPAT: begin
					len  = 32;
					code = EC_COMPAT;
				end
				PH_CONSTR: begin
					len  = 14;
					code = EC_CONSTR;
				end
				PH_RESV: begin
					len      = 33;
					has_code = 1'b0;
				end
				PH_INBLD: begin
					len  = 1;
					code = EC_INBLD;
				end
				default: begin
					len  = 8;
					code = EC_LEVEL;
				end
			endcase
		end
		if (bits_in_field < len)
			return;

		v             = shift_acc;
		bits_in_field = 0;
		shift_acc     = '0;
		layer         = (ph >= PH_SLPF && ph != PH_PAD) ? idx + 3'd1 : 3'd0;
		if (has_code)
			add_elem(code, layer, v[31:0], '0, 1'b0);

		case (ph)
			PH_IDC: begin
				gen_idc   = v[4:0];
				cur_phase = PH_COMPAT;
			end
			PH_COMPAT: begin
				gen_compat = v[31:0];
				cur_phase  = PH_CONSTR;
			end
			PH_LEVEL: begin
				if (sub_count() > 0) begin
					sl_cur    = '0;
					cur_phase = PH_SLPF;
				end else begin
					close_structure();
				end
			end
			PH_SLPF: begin
				if (idx < 7 && v != 0)
					sl_prof_seen[idx] = 1'b1;
				cur_phase = PH_SLLF;
			end
			PH_SLLF: begin
				if (idx < 7 && v != 0)
					sl_lvl_seen[idx] = 1'b1;
				if (int'(idx) + 1 < sub_count()) begin
					sl_cur    = idx + 3'd1;
					cur_phase = PH_SLPF;
				end else begin
					cur_phase = PH_PAD;
				end
			end
			PH_PAD: next_sub_layer(0);
			PH_SL_INBLD: begin
				if (idx < 7 && sl_lvl_seen[idx])
					cur_phase = PH_SL_LEVEL;
				else
					next_sub_layer(int'(idx) + 1);
			end
			PH_SL_LEVEL: next_sub_layer(int'(idx) + 1);
			default: cur_phase = phase_t'(ph + 1);
		endcase
	endfunction

	function automatic void parse_byte(input in_item_t it);
		elems_this_byte = 0;
		for (int i = 7; i >= 0; i--)
			shift_in_bit(it.byte_in[i]);
		if (it.last_byte) begin
			if (cur_phase != PH_FINISHED)
				add_elem(EC_TRUNC, '0, '0, '0, 1'b1);
			restart_structure();
		end
	endfunction

	task automatic check_elem(input out_item_t got);
		out_item_t e;
		if (expected_elems.size() == 0) begin
			report_mismatch("result with nothing expected, code", got.elem_code, 0);
			return;
		end
		e = expected_elems.pop_front();
		if (got.elem_code !== e.elem_code)
			report_mismatch("elem_code", got.elem_code, e.elem_code);
		if (got.layer !== e.layer)
			report_mismatch("layer", got.layer, e.layer);
		if (got.value !== e.value)
			report_mismatch("value", got.value, e.value);
		if (got.effective_profile !== e.effective_profile)
			report_mismatch("effective_profile", got.effective_profile, e.effective_profile);
		if (got.last !== e.last)
			report_mismatch("last", got.last, e.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prof_present  = 1'b1;
			sub_layers_m1 = '0;
			restart_structure();
			expected_elems.delete();
			mismatches    = 0;
			outstanding  <= 0;
		end else begin
			if (out_valid && out_ready)
				check_elem(out_data);
			if (in_valid && in_ready)
				parse_byte(in_data);
			if (cfg_we) begin
				if (cfg_index == CFG_PROFILE_PRESENT)
					prof_present = cfg_wdata[0];
				else if (cfg_index == CFG_MAX_SUB_LAYERS)
					sub_layers_m1 = cfg_wdata[2:0];
			end
			outstanding <= expected_elems.size();
		end
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives profile_tier_level byte streams into the parser: a short directed
// set, then well-formed structures with random content, cut-off structures
// and noise under several register settings, with random idling on both
// sides and one long output hold-off; the checker does the comparing
// ----------------------------------------------------------------------------
module testbench;
	import ptl_pkg::*;

	localparam int RAND_ITEMS         = 160;
	localparam int PROFILE_BLOCK_BITS = 88;
	localparam int HOLD_OFF_CYCLES    = 400;
	localparam int SETTLE_CYCLES      = 30;
	localparam int TIMEOUT_NS         = 2_000_000;

	localparam int FILL_RAND = 0;
	localparam int FILL_ZERO = 1;
	localparam int FILL_ONES = 2;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    mismatches;
	int                    outstanding;

	bit                    bit_q[$];
	in_item_t              byte_q[$];
	bit                    tx_idle = 1'b1;
	bit                    rx_idle = 1'b1;
	bit                    hold_off_req = 1'b0;

	hevc_profile_tier_level_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	ptl_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("** hevc_profile_tier_level_parser: FAILED **");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void push_bits(input int count, input int fill);
		for (int i = 0; i < count; i++) begin
			if (fill == FILL_RAND)
				bit_q.push_back(1'($urandom_range(0, 1)));
			else
				bit_q.push_back(fill == FILL_ONES);
		end
	endfunction

	// builds one structure into byte_q, returns the bytes the parser acts on
	function automatic int build_structure(input bit pp, input logic [2:0] n,
			input logic [6:0] pf, input logic [6:0] lf, input int fill,
			input int extra, input bit cut);
		int       full_bytes;
		int       nbytes;
		in_item_t it;
		bit_q.delete();
		if (pp)
			push_bits(PROFILE_BLOCK_BITS, fill);
		push_bits(8, fill);
		if (n > 0) begin
			for (int i = 0; i < n; i++) begin
				bit_q.push_back(pf[i]);
				bit_q.push_back(lf[i]);
			end
			push_bits(2 * (MAX_SUB_LAYERS_DEF - int'(n)), fill);
			for (int i = 0; i < n; i++) begin
				if (pf[i])
					push_bits(PROFILE_BLOCK_BITS, fill);
				if (lf[i])
					push_bits(8, fill);
			end
		end
		while (bit_q.size() % 8 != 0)
			push_bits(1, fill);
		full_bytes = bit_q.size() / 8;
		nbytes     = full_bytes + extra;
		if (cut && full_bytes > 1)
			nbytes = $urandom_range(1, full_bytes - 1);
		push_bits(extra * 8, fill);
		for (int k = 0; k < nbytes; k++) begin
			for (int j = 0; j < 8; j++)
				it.byte_in[7 - j] = bit_q[k * 8 + j];
			it.last_byte = (k == nbytes - 1);
			byte_q.push_back(it);
		end
		return (nbytes < full_bytes) ? nbytes : full_bytes;
	endfunction

	task automatic send_all();
		int g;
		while (byte_q.size() != 0) begin
			g = tx_idle ? idle_len() : 0;
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_data  <= byte_q.pop_front();
			do @(posedge clk); while (!in_ready);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_cfg(input bit pp, input logic [2:0] n);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PROFILE_PRESENT;
		cfg_wdata <= {{(CFG_DATA_W - 1){1'b0}}, pp};
		@(posedge clk);
		cfg_index <= CFG_MAX_SUB_LAYERS;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// output side
	initial begin
		int g;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				g = HOLD_OFF_CYCLES;
			end else begin
				g = rx_idle ? idle_len() : 0;
			end
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		int         rand_items;
		int         phase_no;
		int         r;
		int         nb;
		bit         pp;
		logic [2:0] n;
		logic [6:0] pf;
		logic [6:0] lf;
		in_item_t   it;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all ones under reset settings: full general block, top profile
		void'(build_structure(1'b1, 3'd0, '0, '0, FILL_ONES, 0, 1'b0));
		send_all();
		drain();

		// no profile, one sub-layer level, a byte after done
		apply_cfg(1'b0, 3'd1);
		void'(build_structure(1'b0, 3'd1, 7'd0, 7'd1, FILL_ZERO, 1, 1'b0));
		// buffer ending early
		void'(build_structure(1'b0, 3'd1, 7'd0, 7'd1, FILL_RAND, 0, 1'b1));
		send_all();
		drain();

		rand_items = 0;
		phase_no   = 0;
		while (rand_items < RAND_ITEMS) begin
			case (phase_no)
				0: begin
					pp = 1'b1;
					n  = 3'd0;
				end
				1: begin
					pp = 1'b0;
					n  = 3'd0;
				end
				2: begin
					pp = 1'b1;
					n  = 3'd7;
				end
				3: begin
					pp = 1'b0;
					n  = 3'd7;
				end
				default: begin
					pp = 1'($urandom_range(0, 1));
					n  = 3'(($urandom_range(0, 4) == 0) ? $urandom_range(4, 7)
						: $urandom_range(0, 3));
				end
			endcase
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			apply_cfg(pp, n);
			if (phase_no == 0) begin
				tx_idle      = 1'b0;
				hold_off_req = 1'b1;
			end
			repeat ((n > 3) ? 2 : $urandom_range(2, 4)) begin
				r = $urandom_range(0, 99);
				for (int i = 0; i < 7; i++) begin
					pf[i] = ($urandom_range(0, (n > 3) ? 3 : 2) == 0);
					lf[i] = ($urandom_range(0, 2) == 0);
				end
				if (r < 70) begin
					nb = build_structure(pp, n, pf, lf, FILL_RAND,
						($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0, 1'b0);
				end else if (r < 85) begin
					nb = build_structure(pp, n, pf, lf, FILL_RAND, 0, 1'b1);
				end else begin
					nb = $urandom_range(1, 4);
					for (int k = 0; k < nb; k++) begin
						it.byte_in   = 8'($urandom_range(0, 255));
						it.last_byte = (k == nb - 1) || ($urandom_range(0, 3) == 0);
						byte_q.push_back(it);
					end
				end
				rand_items += nb;
				send_all();
			end
			drain();
			phase_no++;
		end

		if (mismatches == 0)
			$display("** hevc_profile_tier_level_parser: PASSED **");
		else
			$display("** hevc_profile_tier_level_parser: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/ptl_pkg.sv
rtl/core/ptl_dp.sv
rtl/core/ptl_out.sv
rtl/core/ptl_ctrl.sv
rtl/core/hevc_profile_tier_level_parser.sv
rtl/core/ptl_checker.sv
sim/ptl_checker.sv
sim/testbench.sv
